@@ rtl/core/blp_pkg.sv @@
// shared types, constants and elaboration-time tables for the light shader core
package blp_pkg;

  localparam int VEC_W   = 24;
  localparam int UNIT_W  = 16;
  localparam int INT_W   = 24;
  localparam int COEF_W  = 16;
  localparam int EXP_W   = 16;
  localparam int CFG_W   = 48;
  localparam int CFG_IDX_W = 2;
  localparam int UNIT_FRAC = 14;
  localparam int COS_W   = 15;
  localparam int POW_LAT = 36;
  localparam int HALF_W  = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECULAR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd2;

  localparam logic [CFG_W-1:0] DIFFUSE_RESET  = '0;
  localparam logic [CFG_W-1:0] SPECULAR_RESET = '0;
  localparam logic [EXP_W-1:0] EXPONENT_RESET = 16'd256;

  localparam logic [COS_W-1:0] ONE_Q14 = 15'd16384;

  typedef struct packed {
    logic signed [VEC_W-1:0]  light_x;
    logic signed [VEC_W-1:0]  light_y;
    logic signed [VEC_W-1:0]  light_z;
    logic signed [UNIT_W-1:0] view_x;
    logic signed [UNIT_W-1:0] view_y;
    logic signed [UNIT_W-1:0] view_z;
    logic signed [UNIT_W-1:0] normal_x;
    logic signed [UNIT_W-1:0] normal_y;
    logic signed [UNIT_W-1:0] normal_z;
    logic [INT_W-1:0]         intensity_r;
    logic [INT_W-1:0]         intensity_g;
    logic [INT_W-1:0]         intensity_b;
  } blp_in_t;

  typedef struct packed {
    logic [INT_W-1:0] shade_r;
    logic [INT_W-1:0] shade_g;
    logic [INT_W-1:0] shade_b;
  } blp_out_t;

  // latency of the vector normalizer for a component width
  function automatic int blp_unit_lat(input int w);
    return w + 20;
  endfunction

  function automatic logic [63:0] blp_isqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bsel;
    rem = v;
    res = '0;
    bsel = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bsel) begin
        rem = rem - (res + bsel);
        res = (res >> 1) + bsel;
      end else begin
        res = res >> 1;
      end
      bsel = bsel >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-k) in q1.30
  function automatic logic [30:0] blp_exp_t(input int k);
    logic [63:0] t;
    t = blp_isqrt(64'h0800_0000_0000_0000);
    for (int i = 2; i <= k; i++) begin
      t = blp_isqrt(t << 30);
    end
    return t[30:0];
  endfunction

endpackage

@@ rtl/core/blp_unit3.sv @@
// pipelined 3-vector normalizer: squares, bit-serial square root, long division
module blp_unit3 import blp_pkg::*; #(
  parameter int W = VEC_W
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [W-1:0]      vx,
  input  logic signed [W-1:0]      vy,
  input  logic signed [W-1:0]      vz,
  output logic signed [UNIT_W-1:0] ux,
  output logic signed [UNIT_W-1:0] uy,
  output logic signed [UNIT_W-1:0] uz
);

  localparam int SW = 2 * W;
  localparam int DW = W + UNIT_FRAC + 2;
  localparam int QB = UNIT_FRAC + 1;

  logic [2:0][W-1:0]  mag_in;
  logic [2:0][W-1:0]  mag0;
  logic [2:0]         neg0;
  logic [2:0][SW-1:0] sq1;
  logic [2:0][W-1:0]  mag1;
  logic [2:0]         neg1;
  logic [SW-1:0]      sum2;
  logic [2:0][W-1:0]  mag2;
  logic [2:0]         neg2;

  always_comb begin
    mag_in[0] = vx[W-1] ? W'(-vx) : W'(vx);
    mag_in[1] = vy[W-1] ? W'(-vy) : W'(vy);
    mag_in[2] = vz[W-1] ? W'(-vz) : W'(vz);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0 <= mag_in;
      neg0 <= {vz[W-1], vy[W-1], vx[W-1]};
      for (int i = 0; i < 3; i++) begin
        sq1[i] <= SW'(mag0[i]) * SW'(mag0[i]);
      end
      mag1 <= mag0;
      neg1 <= neg0;
      sum2 <= sq1[0] + sq1[1] + sq1[2];
      mag2 <= mag1;
      neg2 <= neg1;
    end
  end

  // square root, one result bit per stage
  logic [SW-1:0]     srem  [W+1];
  logic [W-1:0]      sroot [W+1];
  logic [2:0][W-1:0] smag  [W+1];
  logic [2:0]        sneg  [W+1];

  assign srem[0]  = sum2;
  assign sroot[0] = '0;
  assign smag[0]  = mag2;
  assign sneg[0]  = neg2;

  for (genvar g = 0; g < W; g++) begin : g_sqrt
    localparam int B = W - 1 - g;
    logic [SW:0] trial;
    logic        ge;
    assign trial = ((SW+1)'(sroot[g]) << (B + 1)) | ((SW+1)'(1) << (2 * B));
    assign ge = {1'b0, srem[g]} >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        srem[g+1]  <= ge ? srem[g] - trial[SW-1:0] : srem[g];
        sroot[g+1] <= ge ? (sroot[g] | (W'(1) << B)) : sroot[g];
        smag[g+1]  <= smag[g];
        sneg[g+1]  <= sneg[g];
      end
    end
  end

  // rounded division of each magnitude by the length
  logic [2:0][DW-1:0] drem [QB+1];
  logic [2:0][QB-1:0] dq   [QB+1];
  logic [W-1:0]       dr   [QB+1];
  logic               dz   [QB+1];
  logic [2:0]         dneg [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= (DW'(smag[W][i]) << UNIT_FRAC) + DW'(sroot[W] >> 1);
      end
      dq[0]   <= '0;
      dr[0]   <= sroot[W];
      dz[0]   <= (sroot[W] == '0);
      dneg[0] <= sneg[W];
    end
  end

  for (genvar g = 0; g < QB; g++) begin : g_div
    localparam int J = QB - 1 - g;
    logic [DW-1:0] dsh;
    assign dsh = DW'(dr[g]) << J;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (drem[g][i] >= dsh) begin
            drem[g+1][i] <= drem[g][i] - dsh;
            dq[g+1][i]   <= dq[g][i] | (QB'(1) << J);
          end else begin
            drem[g+1][i] <= drem[g][i];
            dq[g+1][i]   <= dq[g][i];
          end
        end
        dr[g+1]   <= dr[g];
        dz[g+1]   <= dz[g];
        dneg[g+1] <= dneg[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux <= dz[QB] ? '0 : dneg[QB][0] ? -UNIT_W'(dq[QB][0]) : UNIT_W'(dq[QB][0]);
      uy <= dz[QB] ? '0 : dneg[QB][1] ? -UNIT_W'(dq[QB][1]) : UNIT_W'(dq[QB][1]);
      uz <= dz[QB] ? '0 : dneg[QB][2] ? -UNIT_W'(dq[QB][2]) : UNIT_W'(dq[QB][2]);
    end
  end

endmodule

@@ rtl/core/blp_pow.sv @@
// pipelined power c^e via log2 by repeated squaring and exp2 by root table
module blp_pow import blp_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [COS_W-1:0] c,
  input  logic [EXP_W-1:0] e,
  output logic [COS_W-1:0] p
);

  logic [3:0] s_in;

  always_comb begin
    s_in = '0;
    for (int b = 0; b < COS_W; b++) begin
      if (c[b]) s_in = 4'(COS_W - 1 - b);
    end
  end

  logic [30:0] lx [17];
  logic [15:0] lf [17];
  logic [3:0]  ls [17];
  logic        lz [17];

  always_ff @(posedge clk) begin
    if (en) begin
      lx[0] <= {15'(c << s_in), 16'b0};
      lf[0] <= '0;
      ls[0] <= s_in;
      lz[0] <= (c == '0);
    end
  end

  // one log2 fraction bit per stage
  for (genvar g = 0; g < 16; g++) begin : g_log
    logic [61:0] sq;
    logic [31:0] y;
    assign sq = 62'(lx[g]) * 62'(lx[g]);
    assign y  = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        lx[g+1] <= y[31] ? y[31:1] : y[30:0];
        lf[g+1] <= {lf[g][14:0], y[31]};
        ls[g+1] <= ls[g];
        lz[g+1] <= lz[g];
      end
    end
  end

  logic [19:0] a;
  logic        az;
  logic [35:0] prod;

  assign prod = 36'(e) * 36'(a);

  logic [30:0] ex [17];
  logic [15:0] ef [17];
  logic [3:0]  eq [17];
  logic        eb [17];
  logic        ez [17];

  always_ff @(posedge clk) begin
    if (en) begin
      a  <= {ls[16], 16'b0} - 20'(lf[16]);
      az <= lz[16];
      ex[0] <= 31'h4000_0000;
      ef[0] <= prod[23:8];
      eq[0] <= prod[27:24];
      eb[0] <= (prod[35:24] >= 12'd15);
      ez[0] <= az;
    end
  end

  for (genvar g = 0; g < 16; g++) begin : g_exp
    localparam logic [30:0] TK = blp_exp_t(g + 1);
    logic [61:0] m;
    assign m = 62'(ex[g]) * 62'(TK);
    always_ff @(posedge clk) begin
      if (en) begin
        ex[g+1] <= ef[g][15-g] ? m[60:30] : ex[g];
        ef[g+1] <= ef[g];
        eq[g+1] <= eq[g];
        eb[g+1] <= eb[g];
        ez[g+1] <= ez[g];
      end
    end
  end

  logic [31:0] rnd;
  assign rnd = 32'(ex[16]) + (32'(1) << (eq[16] + 15));

  always_ff @(posedge clk) begin
    if (en) begin
      if (e == '0) begin
        p <= ONE_Q14;
      end else if (ez[16] || eb[16]) begin
        p <= '0;
      end else begin
        p <= COS_W'(rnd >> (eq[16] + 16));
      end
    end
  end

endmodule

@@ rtl/core/blinn_phong_light_shader_core.sv @@
// Blinn-Phong shading core: one word in and one word out per cycle while the output is not
// stalled, through the square-root and divider stages of the light normalizer and of the
// half-vector and normal normalizers, the two dot products, the 36-stage log2/exp2 power
// pipeline and the final coefficient multiplies.
// A stalled output holds the pipeline only while its last stage holds a word.
module blinn_phong_light_shader_core import blp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  blp_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output blp_out_t             out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int LAT_L  = blp_unit_lat(VEC_W);
  localparam int LAT_H  = blp_unit_lat(HALF_W);
  localparam int D_AT   = LAT_L + 2;
  localparam int C_AT   = LAT_L + LAT_H + 2;
  localparam int F_AT   = C_AT + POW_LAT;
  localparam int I_DLY  = F_AT - LAT_L;
  localparam int D_DLY  = F_AT - D_AT;
  localparam int TOT    = F_AT + 2;

  logic [CFG_W-1:0] kd;
  logic [CFG_W-1:0] ks;
  logic [EXP_W-1:0] pexp;

  always_ff @(posedge clk) begin
    if (rst) begin
      kd   <= DIFFUSE_RESET;
      ks   <= SPECULAR_RESET;
      pexp <= EXPONENT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DIFFUSE:  kd   <= cfg_data;
        CFG_SPECULAR: ks   <= cfg_data;
        CFG_EXPONENT: pexp <= cfg_data[EXP_W-1:0];
        default: ;
      endcase
    end
  end

  logic           en;
  logic [TOT-1:0] vld;

  assign en       = !vld[TOT-1] || !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOT-2:0], in_valid};
    end
  end

  // light normalize
  logic signed [UNIT_W-1:0] lu_x, lu_y, lu_z;

  blp_unit3 #(.W(VEC_W)) u_lunit (
    .clk (clk), .en (en),
    .vx (in_data.light_x), .vy (in_data.light_y), .vz (in_data.light_z),
    .ux (lu_x), .uy (lu_y), .uz (lu_z)
  );

  blp_in_t da [LAT_L];

  always_ff @(posedge clk) begin
    if (en) begin
      da[0] <= in_data;
      for (int i = 1; i < LAT_L; i++) da[i] <= da[i-1];
    end
  end

  blp_in_t at_l;
  assign at_l = da[LAT_L-1];

  // half vector and normal normalize
  logic signed [HALF_W-1:0] h_x, h_y, h_z;
  logic signed [UNIT_W-1:0] hu_x, hu_y, hu_z;
  logic signed [UNIT_W-1:0] nn_x, nn_y, nn_z;

  assign h_x = HALF_W'(lu_x) + HALF_W'(at_l.view_x);
  assign h_y = HALF_W'(lu_y) + HALF_W'(at_l.view_y);
  assign h_z = HALF_W'(lu_z) + HALF_W'(at_l.view_z);

  blp_unit3 #(.W(HALF_W)) u_hunit (
    .clk (clk), .en (en),
    .vx (h_x), .vy (h_y), .vz (h_z),
    .ux (hu_x), .uy (hu_y), .uz (hu_z)
  );

  blp_unit3 #(.W(HALF_W)) u_nunit (
    .clk (clk), .en (en),
    .vx (HALF_W'(at_l.normal_x)), .vy (HALF_W'(at_l.normal_y)),
    .vz (HALF_W'(at_l.normal_z)),
    .ux (nn_x), .uy (nn_y), .uz (nn_z)
  );

  // diffuse cosine
  logic signed [31:0] dp [3];
  logic signed [33:0] dd;
  logic [16:0]        dcos;

  assign dd = 34'(dp[0]) + 34'(dp[1]) + 34'(dp[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      dp[0] <= lu_x * at_l.normal_x;
      dp[1] <= lu_y * at_l.normal_y;
      dp[2] <= lu_z * at_l.normal_z;
      dcos  <= (dd > 0) ? dd[30:14] : '0;
    end
  end

  logic [16:0] dline [D_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      dline[0] <= dcos;
      for (int i = 1; i < D_DLY; i++) dline[i] <= dline[i-1];
    end
  end

  logic [3*INT_W-1:0] iline [I_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      iline[0] <= {at_l.intensity_b, at_l.intensity_g, at_l.intensity_r};
      for (int i = 1; i < I_DLY; i++) iline[i] <= iline[i-1];
    end
  end

  // specular cosine and power
  logic signed [31:0] sp [3];
  logic signed [31:0] ds;
  logic [COS_W-1:0]   cval;
  logic [COS_W-1:0]   pw;

  assign ds = sp[0] + sp[1] + sp[2];

  always_ff @(posedge clk) begin
    if (en) begin
      sp[0] <= hu_x * nn_x;
      sp[1] <= hu_y * nn_y;
      sp[2] <= hu_z * nn_z;
      if (ds > 0) begin
        cval <= (ds[29:14] > 16'(ONE_Q14)) ? ONE_Q14 : ds[28:14];
      end else begin
        cval <= '0;
      end
    end
  end

  blp_pow u_pow (
    .clk (clk), .en (en), .c (cval), .e (pexp), .p (pw)
  );

  // coefficient multiplies
  logic [39:0]        ia [3];
  logic [39:0]        is [3];
  logic [16:0]        d1;
  logic [COS_W-1:0]   pw1;
  logic [56:0]        dif [3];
  logic [54:0]        spe [3];
  logic [INT_W-1:0]   iv [3];

  assign iv[0] = iline[I_DLY-1][INT_W-1:0];
  assign iv[1] = iline[I_DLY-1][2*INT_W-1:INT_W];
  assign iv[2] = iline[I_DLY-1][3*INT_W-1:2*INT_W];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ia[i]  <= 40'(iv[i]) * 40'(kd[COEF_W*i +: COEF_W]);
        is[i]  <= 40'(iv[i]) * 40'(ks[COEF_W*i +: COEF_W]);
        dif[i] <= 57'(ia[i]) * 57'(d1);
        spe[i] <= 55'(is[i]) * 55'(pw1);
      end
      d1  <= dline[D_DLY-1];
      pw1 <= pw;
    end
  end

  logic [28:0]      sum [3];
  logic [INT_W-1:0] sat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = 29'(dif[i] >> 29) + 29'(spe[i] >> 29);
      sat[i] = (sum[i] > 29'(24'hFF_FFFF)) ? 24'hFF_FFFF : sum[i][INT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && vld[TOT-1]) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[TOT-1]) begin
      out_data.shade_r <= sat[0];
      out_data.shade_g <= sat[1];
      out_data.shade_b <= sat[2];
    end
  end

`ifndef NO_ASSERTIONS
  // a full last stage behind a stalled word blocks input
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && vld[TOT-1]) |-> !in_ready)
    else $error("input taken while pipeline is blocked");

  // an accepted word enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted word lost at pipeline entry");

  // a word leaving the last stage shows up at the output
  a_leave: assert property (@(posedge clk) disable iff (rst)
    (en && vld[TOT-1]) |=> out_valid)
    else $error("word lost at pipeline exit");

  // a held pipeline keeps its valid bits
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while held");
`endif

endmodule

@@ dv/tb.sv @@
// self-checking testbench for the blinn-phong light shader core
module tb;
  import blp_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  blp_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  blp_out_t             out_data;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  blinn_phong_light_shader_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int PIPE_DEPTH = 123;
  localparam int STALL_LIMIT = 20000;

  logic [47:0] kd_reg;
  logic [47:0] ks_reg;
  logic [15:0] exp_reg;

  blp_out_t shade_q[$];
  int mismatches;
  int words_in;
  int words_out;
  int idle_cycles;
  bit hold_off;
  bit stall_en;
  int burst_left;

  initial begin
    clk = 1'b0;
  end
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void normalize(input longint vx, input longint vy, input longint vz,
                                    output longint ux, output longint uy,
                                    output longint uz);
    longint unsigned ax, ay, az, r;
    ax = vx < 0 ? -vx : vx;
    ay = vy < 0 ? -vy : vy;
    az = vz < 0 ? -vz : vz;
    r = isqrt(ax * ax + ay * ay + az * az);
    if (r == 0) begin
      ux = 0; uy = 0; uz = 0;
    end else begin
      ux = ((ax << 14) + (r >> 1)) / r;
      uy = ((ay << 14) + (r >> 1)) / r;
      uz = ((az << 14) + (r >> 1)) / r;
      if (vx < 0) ux = -ux;
      if (vy < 0) uy = -uy;
      if (vz < 0) uz = -uz;
    end
  endfunction

  function automatic longint unsigned cos_power(input longint unsigned c,
                                                input longint unsigned e);
    longint unsigned m, x, f, a, p, frac, t;
    int s, q;
    if (e == 0) return 16384;
    if (c == 0) return 0;
    m = c;
    s = 0;
    f = 0;
    while (m < (64'd1 << 14)) begin
      m = m << 1;
      s++;
    end
    x = m << 16;
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 30;
      f = f << 1;
      if (x >= (64'd1 << 31)) begin
        f = f | 1;
        x = x >> 1;
      end
    end
    a = (longint'(s) << 16) - f;
    p = (e * a) >> 8;
    if ((p >> 16) >= 15) return 0;
    q = int'(p >> 16);
    frac = p & 16'hffff;
    x = 64'd1 << 30;
    t = isqrt(64'd1 << 59);
    for (int k = 1; k <= 16; k++) begin
      if ((frac >> (16 - k)) & 1) x = (x * t) >> 30;
      t = isqrt(t << 30);
    end
    return (x + (64'd1 << (q + 15))) >> (q + 16);
  endfunction

  function automatic blp_out_t shade_of(input blp_in_t w);
    longint lx, ly, lz, hx, hy, hz, nx, ny, nz, dd, ds;
    longint unsigned d, c, pw, inten, kd, ks, sum;
    logic [INT_W-1:0] ch[3];
    blp_out_t o;
    normalize(longint'(w.light_x), longint'(w.light_y), longint'(w.light_z), lx, ly, lz);
    dd = lx * w.normal_x + ly * w.normal_y + lz * w.normal_z;
    d = dd > 0 ? dd >> 14 : 0;
    normalize(lx + w.view_x, ly + w.view_y, lz + w.view_z, hx, hy, hz);
    normalize(longint'(w.normal_x), longint'(w.normal_y), longint'(w.normal_z),
              nx, ny, nz);
    ds = hx * nx + hy * ny + hz * nz;
    c = ds > 0 ? ds >> 14 : 0;
    if (c > 16384) c = 16384;
    pw = cos_power(c, 64'(exp_reg));
    for (int i = 0; i < 3; i++) begin
      inten = 64'(i == 0 ? w.intensity_r : (i == 1 ? w.intensity_g : w.intensity_b));
      kd = 64'(kd_reg[16 * i +: 16]);
      ks = 64'(ks_reg[16 * i +: 16]);
      sum = ((inten * d * kd) >> 29) + ((inten * ks * pw) >> 29);
      ch[i] = sum > 64'hffffff ? 24'hffffff : sum[23:0];
    end
    o.shade_r = ch[0];
    o.shade_g = ch[1];
    o.shade_b = ch[2];
    return o;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      words_out <= words_out + 1;
      if (shade_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected word %h", out_data);
      end else begin
        if (out_data !== shade_q[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected r=%h g=%h b=%h got r=%h g=%h b=%h",
                     shade_q[0].shade_r, shade_q[0].shade_g, shade_q[0].shade_b,
                     out_data.shade_r, out_data.shade_g, out_data.shade_b);
        end
        void'(shade_q.pop_front());
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if (!stall_en) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 15) > 4);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("watchdog expired");
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_word(input blp_in_t w, input bit gaps);
    int gap;
    gap = 0;
    if (gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    shade_q.push_back(shade_of(w));
    words_in++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (shade_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_DIFFUSE) kd_reg = v;
    else if (idx == CFG_SPECULAR) ks_reg = v;
    else if (idx == CFG_EXPONENT) exp_reg = v[15:0];
    @(posedge clk);
  endtask

  function automatic logic [23:0] rnd_vec;
    case ($urandom_range(0, 3))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'($urandom_range(0, 1) ? $urandom_range(0, 32768)
                                         : -$urandom_range(0, 32768));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rnd_unit;
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0;
      default: return 16'($urandom_range(0, 1) ? $urandom_range(0, 16384)
                                                : -$urandom_range(0, 16384));
    endcase
  endfunction

  function automatic blp_in_t rnd_word;
    blp_in_t w;
    w.light_x = rnd_vec();
    w.light_y = rnd_vec();
    w.light_z = rnd_vec();
    w.view_x = rnd_unit();
    w.view_y = rnd_unit();
    w.view_z = rnd_unit();
    w.normal_x = rnd_unit();
    w.normal_y = rnd_unit();
    w.normal_z = rnd_unit();
    w.intensity_r = $urandom_range(0, 3) == 0 ? 24'hffffff : 24'($urandom);
    w.intensity_g = $urandom_range(0, 3) == 0 ? 24'h000100 : 24'($urandom);
    w.intensity_b = 24'($urandom);
    return w;
  endfunction

  function automatic blp_in_t make_word(input logic [23:0] l0, l1, l2,
                                        input logic [15:0] v0, v1, v2, n0, n1, n2,
                                        input logic [23:0] ir);
    blp_in_t w;
    w.light_x = l0; w.light_y = l1; w.light_z = l2;
    w.view_x = v0; w.view_y = v1; w.view_z = v2;
    w.normal_x = n0; w.normal_y = n1; w.normal_z = n2;
    w.intensity_r = ir; w.intensity_g = ir; w.intensity_b = ir;
    return w;
  endfunction

  task automatic test_directed;
    write_reg(CFG_DIFFUSE, 48'h8000_8000_8000);
    write_reg(CFG_SPECULAR, 48'h8000_4000_ffff);
    send_word(make_word(24'h001000, 24'h0, 24'h0, 16'h4000, 16'h0, 16'h0,
                        16'h4000, 16'h0, 16'h0, 24'h000100), 0);
    send_word(make_word(24'h0, 24'h0, 24'h0, 16'h0, 16'h0, 16'h4000,
                        16'h0, 16'h0, 16'h4000, 24'h000100), 0);
    send_word(make_word(24'h001000, 24'h001000, 24'h0, 16'h0, 16'h4000, 16'h0,
                        16'h0, 16'h0, 16'h0, 24'h001000), 0);
    send_word(make_word(24'h7fffff, 24'h7fffff, 24'h7fffff, 16'h7fff, 16'h7fff, 16'h7fff,
                        16'h7fff, 16'h7fff, 16'h7fff, 24'hffffff), 0);
    send_word(make_word(24'h800000, 24'h800000, 24'h800000, 16'h8000, 16'h8000, 16'h8000,
                        16'h8000, 16'h8000, 16'h8000, 24'hffffff), 0);
    send_word(make_word(24'h001000, 24'h0, 24'h0, 16'hc000, 16'h0, 16'h0,
                        16'h4000, 16'h0, 16'h0, 24'h000100), 0);
    send_word(make_word(24'h000001, 24'h0, 24'h0, 16'h0, 16'h4000, 16'h0,
                        16'h2d41, 16'h2d41, 16'h0, 24'h123456), 0);
    send_word(make_word(24'h010000, 24'hff0000, 24'h000800, 16'h2000, 16'h3000, 16'h1000,
                        16'h0, 16'h4000, 16'h0, 24'h000000), 0);
    drain();
    write_reg(CFG_EXPONENT, 48'h0000);
    send_word(make_word(24'h001000, 24'h0, 24'h0, 16'h0, 16'h0, 16'h0,
                        16'h0, 16'h0, 16'h0, 24'h000200), 0);
    send_word(make_word(24'h001000, 24'h0, 24'h0, 16'hc000, 16'h0, 16'h0,
                        16'h4000, 16'h0, 16'h0, 24'hffffff), 0);
    drain();
    write_reg(CFG_EXPONENT, 48'hffff);
    write_reg(CFG_DIFFUSE, 48'hffff_ffff_ffff);
    write_reg(CFG_SPECULAR, 48'hffff_ffff_ffff);
    send_word(make_word(24'h001000, 24'h0, 24'h0, 16'h0, 16'h4000, 16'h0,
                        16'h2d41, 16'h2d41, 16'h0, 24'hffffff), 0);
    send_word(make_word(24'h001000, 24'h0, 24'h0, 16'h4000, 16'h0, 16'h0,
                        16'h4000, 16'h0, 16'h0, 24'h000100), 0);
    drain();
  endtask

  task automatic test_random(input int n, input logic [15:0] e);
    write_reg(CFG_DIFFUSE, 48'({$urandom, $urandom}));
    write_reg(CFG_SPECULAR, 48'({$urandom, $urandom}));
    write_reg(CFG_EXPONENT, 48'(e));
    for (int i = 0; i < n; i++) send_word(rnd_word(), 1);
    drain();
  endtask

  task automatic test_backpressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 200; i++) send_word(rnd_word(), 0);
    join
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_DIFFUSE;
    cfg_data = '0;
    out_ready = 1'b0;
    mismatches = 0;
    words_in = 0;
    words_out = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    stall_en = 1'b0;
    burst_left = 0;
    kd_reg = DIFFUSE_RESET;
    ks_reg = SPECULAR_RESET;
    exp_reg = EXPONENT_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_word(make_word(24'h001000, 24'h0, 24'h0, 16'h4000, 16'h0, 16'h0,
                        16'h4000, 16'h0, 16'h0, 24'h000100), 0);
    drain();
    test_directed();
    test_random(300, 16'h0100);
    stall_en = 1'b1;
    test_random(250, 16'h2000);
    test_random(250, 16'($urandom));
    test_backpressure();
    stall_en = 1'b0;
    test_random(200, 16'h0080);
    $display("covered %0d words in, %0d out, exponents 0 to max, full backpressure",
             words_in, words_out);
    if (mismatches == 0 && shade_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
